### src/rhsl_pkg.sv
// Shared types and constants for the RGB to hue / saturation / lightness converter.
package rhsl_pkg;

    // Output field widths
    localparam int HUE_BITS  = 13;
    localparam int SAT_BITS  = 8;
    localparam int LIT_BITS  = 8;

    // Hue scale: 1/16 degree, 60 degrees per sector, full turn of 360 degrees
    localparam int HUE_SECTOR = 960;
    localparam int HUE_TURN   = 5760;
    // Quotient bits of the hue offset (offset never exceeds HUE_SECTOR)
    localparam int HUE_QBITS  = 10;

    // Sector base angles
    localparam logic [HUE_BITS-1:0] HUE_BASE_R = HUE_BITS'(0);
    localparam logic [HUE_BITS-1:0] HUE_BASE_G = HUE_BITS'(2 * HUE_SECTOR);
    localparam logic [HUE_BITS-1:0] HUE_BASE_B = HUE_BITS'(4 * HUE_SECTOR);

    // Result bus width, packed fields rounded up to whole bytes
    localparam int M_TDATA_W = ((HUE_BITS + SAT_BITS + LIT_BITS + 7) / 8) * 8;

    // Per-pixel info that rides alongside the divider chain
    typedef struct packed {
        logic                grey;      // max equals min
        logic                neg;       // hue difference is negative
        logic [HUE_BITS-1:0] base;      // sector base angle
        logic [LIT_BITS-1:0] lightness; // final lightness value
    } rhsl_side_t;

endpackage

### src/rgb_to_hue_saturation_lightness_core.sv
// Top level of the RGB to hue / saturation / lightness converter.
//
// Usage:
//   Input stream s_*: one RGB pixel per transaction, s_tdata holds red, green
//   and blue, CHANNEL_BITS each, red in the lowest bits.
//   Result stream m_*: one transaction per pixel, m_tdata holds hue (13 bits,
//   1/16 degree), saturation (8 bits) and lightness (8 bits), hue lowest.
//   Pipeline: front stage, N = max(CHANNEL_BITS, 10) division cells, result
//   register. Throughput: one pixel per cycle while not stalled. Each cell of
//   the chain retires one quotient bit of both divisions, so a new pixel
//   enters every cycle unless the chain holds (see Stall below).
//   Reset: aresetn low clears all valid flags; the pipe comes up empty and
//   s_tready is high.
//   Stall: while m_tvalid is high and m_tready low, the whole chain holds
//   and s_tready drops; nothing is lost or repeated.
module rgb_to_hue_saturation_lightness_core #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // red, green, blue (CHANNEL_BITS each), zero pad
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]           s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // hue [12:0], saturation [20:13], lightness [28:21], zero pad
    output logic [rhsl_pkg::M_TDATA_W-1:0]                m_tdata
);
    import rhsl_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int N  = (CB > HUE_QBITS) ? CB : HUE_QBITS;

    logic                 advance;
    logic [CB-1:0]        red, green, blue;

    // Chain links, index 0 is the front stage output
    logic                 valid_a [0:N];
    rhsl_side_t           side_a  [0:N];
    logic [CB-1:0]        srem_a  [0:N];
    logic [N-1:0]         sq_a    [0:N];
    logic [CB-1:0]        sdiv_a  [0:N];
    logic [CB-1:0]        hrem_a  [0:N];
    logic [N-1:0]         hq_a    [0:N];
    logic [CB-1:0]        hdiv_a  [0:N];

    logic [HUE_BITS-1:0]  hue;
    logic [SAT_BITS-1:0]  saturation;
    logic [LIT_BITS-1:0]  lightness;

    // Whole pipe moves unless the result register is full and not taken
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    assign red   = s_tdata[CB-1:0];
    assign green = s_tdata[2*CB-1:CB];
    assign blue  = s_tdata[3*CB-1:2*CB];

    rhsl_front #(.CB(CB), .N(N)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (valid_a[0]),
        .side_out  (side_a[0]),
        .srem      (srem_a[0]),
        .sq        (sq_a[0]),
        .sdiv      (sdiv_a[0]),
        .hrem      (hrem_a[0]),
        .hq        (hq_a[0]),
        .hdiv      (hdiv_a[0])
    );

    // Division cells, one quotient bit each
    for (genvar i = 0; i < N; i++) begin : g_cell
        rhsl_div_cell #(.CB(CB), .N(N)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_a[i]),
            .side_in   (side_a[i]),
            .srem_in   (srem_a[i]),
            .sq_in     (sq_a[i]),
            .sdiv_in   (sdiv_a[i]),
            .hrem_in   (hrem_a[i]),
            .hq_in     (hq_a[i]),
            .hdiv_in   (hdiv_a[i]),
            .out_valid (valid_a[i+1]),
            .side_out  (side_a[i+1]),
            .srem_out  (srem_a[i+1]),
            .sq_out    (sq_a[i+1]),
            .sdiv_out  (sdiv_a[i+1]),
            .hrem_out  (hrem_a[i+1]),
            .hq_out    (hq_a[i+1]),
            .hdiv_out  (hdiv_a[i+1])
        );
    end

    rhsl_back #(.CB(CB), .N(N)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_valid   (valid_a[N]),
        .side_in    (side_a[N]),
        .sq_in      (sq_a[N]),
        .hrem_in    (hrem_a[N]),
        .hq_in      (hq_a[N]),
        .out_valid  (m_tvalid),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    assign m_tdata = M_TDATA_W'({lightness, saturation, hue});

endmodule

### src/rhsl_front.sv
// Input stage: max/min, sector select, dividend setup for both divisions.
module rhsl_front #(
    parameter int CB = 8,
    parameter int N  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [CB-1:0]         red,
    input  logic [CB-1:0]         green,
    input  logic [CB-1:0]         blue,
    output logic                  out_valid,
    output rhsl_pkg::rhsl_side_t  side_out,
    output logic [CB-1:0]         srem,
    output logic [N-1:0]          sq,
    output logic [CB-1:0]         sdiv,
    output logic [CB-1:0]         hrem,
    output logic [N-1:0]          hq,
    output logic [CB-1:0]         hdiv
);
    import rhsl_pkg::*;

    localparam int DW = N + CB;
    localparam int LW = (CB > LIT_BITS) ? CB : LIT_BITS;

    logic [CB-1:0]        mx, mn, delta, absd;
    logic signed [CB:0]   diff;
    logic [CB:0]          absd_full;
    logic [2*CB-1:0]      sat_prod;
    logic [DW-1:0]        sat_dvd, hue_dvd;
    logic [CB:0]          lit_sum;
    logic [LW-1:0]        lit_ext;
    logic [HUE_BITS-1:0]  base;
    rhsl_side_t           side_next;

    logic                 valid_reg;
    rhsl_side_t           side_reg;
    logic [CB-1:0]        srem_reg, sdiv_reg, hrem_reg, hdiv_reg;
    logic [N-1:0]         sq_reg, hq_reg;

    // Largest and smallest channel
    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        delta = mx - mn;
    end

    // Sector choice, ties go red then green then blue
    always_comb begin
        if (mx == red) begin
            base = HUE_BASE_R;
            diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (mx == green) begin
            base = HUE_BASE_G;
            diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            base = HUE_BASE_B;
            diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        absd_full = diff[CB] ? (~diff + 1'b1) : diff;
        absd      = absd_full[CB-1:0];
    end

    // Dividends: full-scale times delta, and sector span times |diff|
    always_comb begin
        sat_prod = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};
        sat_dvd  = DW'(sat_prod);
        hue_dvd  = DW'(absd) * DW'(HUE_SECTOR);
        lit_sum  = {1'b0, mx} + {1'b0, mn};
        lit_ext  = LW'(lit_sum[CB:1]);
        side_next.grey      = (delta == '0);
        side_next.neg       = diff[CB];
        side_next.base      = base;
        side_next.lightness = lit_ext[LIT_BITS-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // Payload; the quotient will be below 2^N, so the upper dividend bits seed the remainder
    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= side_next;
            srem_reg <= sat_dvd[DW-1:N];
            sq_reg   <= sat_dvd[N-1:0];
            sdiv_reg <= mx;
            hrem_reg <= hue_dvd[DW-1:N];
            hq_reg   <= hue_dvd[N-1:0];
            hdiv_reg <= delta;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign srem      = srem_reg;
    assign sq        = sq_reg;
    assign sdiv      = sdiv_reg;
    assign hrem      = hrem_reg;
    assign hq        = hq_reg;
    assign hdiv      = hdiv_reg;

endmodule

### src/rhsl_div_cell.sv
// One restoring-division step for both the saturation and hue quotients.
module rhsl_div_cell #(
    parameter int CB = 8,
    parameter int N  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  rhsl_pkg::rhsl_side_t  side_in,
    input  logic [CB-1:0]         srem_in,
    input  logic [N-1:0]          sq_in,
    input  logic [CB-1:0]         sdiv_in,
    input  logic [CB-1:0]         hrem_in,
    input  logic [N-1:0]          hq_in,
    input  logic [CB-1:0]         hdiv_in,
    output logic                  out_valid,
    output rhsl_pkg::rhsl_side_t  side_out,
    output logic [CB-1:0]         srem_out,
    output logic [N-1:0]          sq_out,
    output logic [CB-1:0]         sdiv_out,
    output logic [CB-1:0]         hrem_out,
    output logic [N-1:0]          hq_out,
    output logic [CB-1:0]         hdiv_out
);
    import rhsl_pkg::*;

    logic [CB:0]    s_trial, h_trial;
    logic           s_ge, h_ge;
    logic [CB:0]    s_diff, h_diff;
    logic [CB-1:0]  srem_next, hrem_next;
    logic [N-1:0]   sq_next, hq_next;

    logic           valid_reg;
    rhsl_side_t     side_reg;
    logic [CB-1:0]  srem_reg, sdiv_reg, hrem_reg, hdiv_reg;
    logic [N-1:0]   sq_reg, hq_reg;

    // Shift in next dividend bit, subtract divisor if it fits, shift in quotient bit
    always_comb begin
        s_trial   = {srem_in, sq_in[N-1]};
        s_ge      = (s_trial >= {1'b0, sdiv_in});
        s_diff    = s_trial - {1'b0, sdiv_in};
        srem_next = s_ge ? s_diff[CB-1:0] : s_trial[CB-1:0];
        sq_next   = {sq_in[N-2:0], s_ge};

        h_trial   = {hrem_in, hq_in[N-1]};
        h_ge      = (h_trial >= {1'b0, hdiv_in});
        h_diff    = h_trial - {1'b0, hdiv_in};
        hrem_next = h_ge ? h_diff[CB-1:0] : h_trial[CB-1:0];
        hq_next   = {hq_in[N-2:0], h_ge};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= side_in;
            srem_reg <= srem_next;
            sq_reg   <= sq_next;
            sdiv_reg <= sdiv_in;
            hrem_reg <= hrem_next;
            hq_reg   <= hq_next;
            hdiv_reg <= hdiv_in;
        end
    end

    assign out_valid = valid_reg;
    assign side_out  = side_reg;
    assign srem_out  = srem_reg;
    assign sq_out    = sq_reg;
    assign sdiv_out  = sdiv_reg;
    assign hrem_out  = hrem_reg;
    assign hq_out    = hq_reg;
    assign hdiv_out  = hdiv_reg;

`ifndef NO_ASSERTIONS
    // Partial remainder stays below the divisor for any non-grey pixel
    a_srem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !side_reg.grey) |-> (srem_reg < sdiv_reg))
        else $error("saturation remainder not below divisor");

    a_hrem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !side_reg.grey) |-> (hrem_reg < hdiv_reg))
        else $error("hue remainder not below divisor");

    // A stalled chain keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && valid_reg) |=> (valid_reg && $stable(sq_reg) && $stable(hq_reg)
                                     && $stable(hrem_reg) && $stable(side_reg)))
        else $error("division cell changed while stalled");
`endif

endmodule

### src/rhsl_back.sv
// Output stage: signs and wraps the hue offset, masks fields, holds the result transaction.
module rhsl_back #(
    parameter int CB = 8,
    parameter int N  = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              in_valid,
    input  rhsl_pkg::rhsl_side_t              side_in,
    input  logic [N-1:0]                      sq_in,
    input  logic [CB-1:0]                     hrem_in,
    input  logic [N-1:0]                      hq_in,
    output logic                              out_valid,
    output logic [rhsl_pkg::HUE_BITS-1:0]     hue,
    output logic [rhsl_pkg::SAT_BITS-1:0]     saturation,
    output logic [rhsl_pkg::LIT_BITS-1:0]     lightness
);
    import rhsl_pkg::*;

    logic [HUE_QBITS:0]   mag;
    logic [HUE_BITS-1:0]  mag_ext, base_adj;
    logic [HUE_BITS-1:0]  hue_next;
    logic [SAT_BITS-1:0]  sat_next;

    logic                 valid_reg;
    logic [HUE_BITS-1:0]  hue_reg;
    logic [SAT_BITS-1:0]  sat_reg;
    logic [LIT_BITS-1:0]  lit_reg;

    // Floor of a negative quotient rounds away from zero when there is a remainder
    always_comb begin
        mag      = {1'b0, hq_in[HUE_QBITS-1:0]}
                 + (HUE_QBITS+1)'(side_in.neg && (hrem_in != '0));
        mag_ext  = HUE_BITS'(mag);
        base_adj = (side_in.neg && (side_in.base == HUE_BASE_R))
                 ? HUE_BITS'(HUE_TURN) : side_in.base;
        if (side_in.grey) begin
            hue_next = '0;
            sat_next = '0;
        end else begin
            hue_next = side_in.neg ? (base_adj - mag_ext) : (base_adj + mag_ext);
            sat_next = sq_in[SAT_BITS-1:0];
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lit_reg <= side_in.lightness;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lit_reg;

endmodule

### tb/rgb_to_hue_saturation_lightness_core_tb.sv
// Testbench for the RGB to hue / saturation / lightness converter.
`timescale 1ns / 100ps

module rgb_to_hue_saturation_lightness_core_tb;

    import rhsl_pkg::*;

    localparam int CHANNEL_BITS = 8;
    localparam int S_TDATA_W    = ((3 * CHANNEL_BITS + 7) / 8) * 8;
    localparam int CHAN_FULL    = (1 << CHANNEL_BITS) - 1;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int LONG_HOLD    = 80;    // receiver hold, well past the pipe depth
    localparam int FLUSH_CYCLES = 20;    // idle margin at the end, longer than the pipe depth

    // Red in the lowest bits, matching s_tdata
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] red;
    } pixel_t;

    // Hue in the lowest bits, matching m_tdata
    typedef struct packed {
        logic [LIT_BITS-1:0] lightness;
        logic [SAT_BITS-1:0] saturation;
        logic [HUE_BITS-1:0] hue;
    } hsl_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    pixel_t pixel_q[$];
    hsl_t   hsl_expected_q[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     fail_count    = 0;
    int     quiet_cycles  = 0;
    int     hold_left     = 0;
    logic   hold_request  = 1'b0;
    logic   hold_taken    = 1'b0;

    rgb_to_hue_saturation_lightness_core #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Expected HSL for one pixel
    function automatic hsl_t rgb_to_hsl(pixel_t px);
        int   r, g, b, mx, mn, delta, base, diff, num, hue_v;
        hsl_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res.hue        = '0;
        res.saturation = '0;
        res.lightness  = LIT_BITS'((mx + mn) >> 1);
        if (delta > 0) begin
            res.saturation = SAT_BITS'((CHAN_FULL * delta) / mx);
            // sector ties go red, then green, then blue
            if (mx == r) begin
                base = 0;
                diff = g - b;
            end else if (mx == g) begin
                base = 2 * HUE_SECTOR;
                diff = b - r;
            end else begin
                base = 4 * HUE_SECTOR;
                diff = r - g;
            end
            // offset floors toward minus infinity
            num = HUE_SECTOR * diff;
            if (num >= 0)
                hue_v = base + num / delta;
            else
                hue_v = base - (-num + delta - 1) / delta;
            if (hue_v < 0)
                hue_v += HUE_TURN;
            res.hue = HUE_BITS'(hue_v);
        end
        return res;
    endfunction

    // Channel level for the tie / extreme mix: zero, full scale or a shared value
    function automatic logic [CHANNEL_BITS-1:0] pick_level(logic [CHANNEL_BITS-1:0] shared);
        case ($urandom_range(2))
            0:       return '0;
            1:       return '1;
            default: return shared;
        endcase
    endfunction

    task automatic queue_pixel(input int r, input int g, input int b);
        pixel_t px;
        px.red   = CHANNEL_BITS'(r);
        px.green = CHANNEL_BITS'(g);
        px.blue  = CHANNEL_BITS'(b);
        pixel_q.push_back(px);
    endtask

    // Mostly uniform pixels, plus near-grey ones and ties between channels
    task automatic queue_random(input int count);
        pixel_t                  px;
        int                      kind;
        logic [CHANNEL_BITS-1:0] shared;
        for (int i = 0; i < count; i++) begin
            kind   = $urandom_range(99);
            px     = pixel_t'($urandom);
            shared = CHANNEL_BITS'($urandom);
            if (kind < 15) begin
                px.green = CHANNEL_BITS'(px.red + $urandom_range(2) - 1);
                px.blue  = CHANNEL_BITS'(px.red + $urandom_range(2) - 1);
            end else if (kind < 35) begin
                px.red   = pick_level(shared);
                px.green = pick_level(shared);
                px.blue  = pick_level(shared);
            end
            pixel_q.push_back(px);
        end
    endtask

    // Wait until every queued pixel has been accepted and answered
    task automatic drain();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_tvalid || hsl_expected_q.size() != 0);
    endtask

    // Input driver: records the expectation on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                hsl_expected_q.push_back(rgb_to_hsl(pixel_t'(s_tdata[3*CHANNEL_BITS-1:0])));
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= S_TDATA_W'(pixel_q.pop_front());
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin
        hsl_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = hsl_t'(m_tdata[HUE_BITS+SAT_BITS+LIT_BITS-1:0]);
                if (hsl_expected_q.size() == 0) begin
                    $display("%0t: unexpected result hue=%0d sat=%0d lit=%0d",
                             $time, got.hue, got.saturation, got.lightness);
                    fail_count++;
                end else begin
                    want = hsl_expected_q.pop_front();
                    if (got.hue != want.hue) begin
                        $display("%0t: hue mismatch expected %0d actual %0d",
                                 $time, want.hue, got.hue);
                        fail_count++;
                    end
                    if (got.saturation != want.saturation) begin
                        $display("%0t: saturation mismatch expected %0d actual %0d",
                                 $time, want.saturation, got.saturation);
                        fail_count++;
                    end
                    if (got.lightness != want.lightness) begin
                        $display("%0t: lightness mismatch expected %0d actual %0d",
                                 $time, want.lightness, got.lightness);
                        fail_count++;
                    end
                end
            end
            // long hold lets the pipe fill and stall the input side
            if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= LONG_HOLD;
                m_tready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d pixels pending, %0d results outstanding",
                     $time, pixel_q.size(), hsl_expected_q.size());
            $display("** rgb_to_hue_saturation_lightness_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 21;
        recv_idle_pct = 73;
        // greys at both ends and mid scale
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        // primaries and secondaries
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);   // red/green tie goes red
        queue_pixel(0, 255, 255);   // green/blue tie goes green
        queue_pixel(255, 0, 255);   // red/blue tie, negative diff wraps
        // negative hue wrap near a full turn
        queue_pixel(255, 0, 1);
        queue_pixel(255, 254, 255);
        // smallest deltas
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(255, 254, 254);
        queue_pixel(254, 255, 255);
        // sector edges and rounding
        queue_pixel(254, 255, 0);
        queue_pixel(0, 254, 255);
        queue_pixel(255, 128, 0);
        queue_pixel(1, 255, 0);
        queue_pixel(170, 85, 42);
        queue_pixel(3, 1, 2);
        queue_random(340);
        drain();

        // heavy sender idling, light receiver idling
        send_idle_pct = 73;
        recv_idle_pct = 21;
        queue_random(350);
        drain();

        // full rate both ways, with one long receiver hold
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(400);
        hold_request = 1'b1;
        drain();

        repeat (FLUSH_CYCLES) @(negedge aclk);
        if (fail_count == 0 && hsl_expected_q.size() == 0) begin
            $display("** rgb_to_hue_saturation_lightness_core: PASSED **");
        end else begin
            $display("** rgb_to_hue_saturation_lightness_core: FAILED **");
        end
        $finish;
    end

endmodule
